// ===== design/tksel_pkg.sv =====
// Package for the top-K similarity selector: widths, item types and the ranking function.
package tksel_pkg;

  // Field widths fixed by the item formats.
  localparam int ID_W       = 31;
  localparam int SCORE_W    = 32;
  localparam int RANK_W     = 4;
  localparam int NC_W       = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  // Default capacity of the kept list.
  localparam int K_MAX_DEF = 16;

  // Reset value of the neighbor count register.
  localparam logic [NC_W-1:0] NC_RESET = NC_W'(16);

  // Clamp limits in Q7.24.
  localparam logic signed [SCORE_W-1:0] ONE_Q24       = 32'sh0100_0000;
  localparam logic signed [SCORE_W-1:0] MINUS_ONE_Q24 = -32'sh0100_0000;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBOR_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAMP_ENABLE   = 1'b1;

  // One input item.
  typedef struct packed {
    logic [ID_W-1:0]           query_id;
    logic [ID_W-1:0]           candidate_id;
    logic signed [SCORE_W-1:0] candidate_score;
    logic                      last_candidate;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [ID_W-1:0]           neighbor_id;
    logic signed [SCORE_W-1:0] neighbor_score;
    logic                      last_neighbor;
    logic                      too_few;
  } out_item_t;

  // Contents of one list cell.
  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctrl_t;

  // True when entry a ranks strictly above entry b: higher score, then lower index.
  function automatic logic ranks_above(logic signed [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                       logic signed [SCORE_W-1:0] sb, logic [ID_W-1:0] ib);
    return (sa > sb) || ((sa == sb) && (ia < ib));
  endfunction

endpackage

// ===== design/tksel_cell.sv =====
// One cell of the sorted list: holds an entry, inserts, shifts down on insert, up on emit.
module tksel_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tksel_pkg::cell_ctrl_t              ctrl,
  input  logic                               en,
  input  logic [tksel_pkg::ID_W-1:0]         cand_id,
  input  logic signed [tksel_pkg::SCORE_W-1:0] cand_score,
  input  tksel_pkg::entry_t                  prev_ent,
  input  logic                               prev_beats,
  input  tksel_pkg::entry_t                  next_ent,
  output tksel_pkg::entry_t                  ent,
  output logic                               beats
);
  import tksel_pkg::*;

  logic                valid_r, valid_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;

  assign ent = '{valid: valid_r, id: id_r, score: score_r};

  // An empty or disabled cell loses to any candidate.
  assign beats = !(valid_r && en) || ranks_above(cand_score, cand_id, score_r, id_r);

  // Next contents: clear, shift up from the next cell, or insert.
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    score_nxt = score_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      valid_nxt = next_ent.valid;
      id_nxt    = next_ent.id;
      score_nxt = next_ent.score;
    end else if (ctrl.ins) begin
      if (!en) begin
        valid_nxt = 1'b0;
      end else if (beats && prev_beats) begin
        valid_nxt = prev_ent.valid;
        id_nxt    = prev_ent.id;
        score_nxt = prev_ent.score;
      end else if (beats) begin
        valid_nxt = 1'b1;
        id_nxt    = cand_id;
        score_nxt = cand_score;
      end
    end
  end

  // Valid flag is control state; the entry payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    score_r <= score_nxt;
  end

endmodule

// ===== design/top_k_similarity_select.sv =====
// Top level of the top-K similarity selector: configuration, clamp, cell chain and emit control.
// Throughput: one item per cycle while busy is low; an item is inserted into the list as it is accepted.
// An item with last_candidate raises busy for the emit pass, one result per cycle for the
// effective neighbor count (one flagged result when too few), set by the shift-up of the cell chain.
// The last item moves the state to emit, where each result is registered; busy falls with the final one.
// Synchronous active-low reset empties the list, sets neighbor_count to 16 and clamp off.
module top_k_similarity_select #(
  parameter int K_MAX = tksel_pkg::K_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tksel_pkg::in_item_t               in_data,
  output logic                              out_valid,
  output tksel_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [tksel_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tksel_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tksel_pkg::*;

  localparam int CW   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KW   = $clog2(K_MAX + 1);
  localparam int CMPW = (KW > NC_W) ? KW : NC_W;

  typedef enum logic {ST_RUN, ST_EMIT} state_t;

  state_t          state_r;
  logic            out_valid_r;
  out_item_t       out_data_r;
  logic [CW-1:0]   rank_r;
  logic [NC_W-1:0] nc_r;
  logic            clamp_r;

  logic               accept;
  logic [KW-1:0]      k;
  logic [KW-1:0]      k_m1;
  logic [CMPW-1:0]    nc_ext;
  logic [CMPW-1:0]    k_cmp;
  logic signed [SCORE_W-1:0] cand_score;
  cell_ctrl_t         ctrl;
  logic               emit_err;
  logic               emit_final;

  entry_t             c_ent   [K_MAX];
  logic               c_beats [K_MAX];
  logic [K_MAX-1:0]   c_en;
  logic [K_MAX-1:0]   c_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r    <= NC_RESET;
      clamp_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NEIGHBOR_COUNT: nc_r    <= cfg_wdata[NC_W-1:0];
        CFG_CLAMP_ENABLE:   clamp_r <= cfg_wdata[0];
        default:            ;
      endcase
    end
  end

  // Effective list length: zero acts as one, values above capacity act as the capacity.
  always_comb begin
    nc_ext = CMPW'(nc_r);
    if (nc_ext == '0) begin
      k_cmp = CMPW'(1);
    end else if (nc_ext > CMPW'(K_MAX)) begin
      k_cmp = CMPW'(K_MAX);
    end else begin
      k_cmp = nc_ext;
    end
    k    = KW'(k_cmp);
    k_m1 = k - KW'(1);
  end

  // Optional clamp of the score to the range -1.0 to 1.0.
  always_comb begin
    cand_score = in_data.candidate_score;
    if (clamp_r) begin
      if (cand_score > ONE_Q24) begin
        cand_score = ONE_Q24;
      end else if (cand_score < MINUS_ONE_Q24) begin
        cand_score = MINUS_ONE_Q24;
      end
    end
  end

  assign busy   = (state_r == ST_EMIT);
  assign accept = start && !busy;

  // The list is full when the cell at the last kept position holds an entry.
  assign emit_err   = (rank_r == '0) && !c_valid[k_m1[CW-1:0]];
  assign emit_final = (rank_r == k_m1[CW-1:0]);

  // Commands to the chain.
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_RUN: begin
        ctrl.ins = accept && (in_data.candidate_id != in_data.query_id);
      end
      ST_EMIT: begin
        if (emit_err || emit_final) begin
          ctrl.clr = 1'b1;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Cell chain: cell 0 holds the best entry.
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_beats;

    assign c_en[i]    = (KW'(i) < k);
    assign c_valid[i] = c_ent[i].valid;

    if (i == 0) begin : g_first
      assign prev_ent   = '0;
      assign prev_beats = 1'b0;
    end else begin : g_mid
      assign prev_ent   = c_ent[i-1];
      assign prev_beats = c_beats[i-1];
    end

    if (i == K_MAX - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = c_ent[i+1];
    end

    tksel_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .en         (c_en[i]),
      .cand_id    (in_data.candidate_id),
      .cand_score (cand_score),
      .prev_ent   (prev_ent),
      .prev_beats (prev_beats),
      .next_ent   (next_ent),
      .ent        (c_ent[i]),
      .beats      (c_beats[i])
    );
  end

  // Sequencer: accepts items, then emits the list best first from cell 0, or a too-few flag if short.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      rank_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_RUN: begin
          if (accept && in_data.last_candidate) begin
            state_r <= ST_EMIT;
            rank_r  <= '0;
          end
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          if (emit_err) begin
            out_data_r <= '{rank: '0, neighbor_id: '0, neighbor_score: '0,
                            last_neighbor: 1'b1, too_few: 1'b1};
            state_r    <= ST_RUN;
          end else begin
            out_data_r <= '{rank: RANK_W'(rank_r), neighbor_id: c_ent[0].id,
                            neighbor_score: c_ent[0].score,
                            last_neighbor: emit_final, too_few: 1'b0};
            rank_r     <= rank_r + CW'(1);
            if (emit_final) begin
              state_r <= ST_RUN;
            end
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/tksel_checker.sv =====
// Port-level checker for the top-K similarity selector and its bind to the top level.
module tksel_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input tksel_pkg::out_item_t out_data,
  input logic                 out_valid
);
  import tksel_pkg::*;

  // The final result of a query ends the busy period.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_neighbor |-> !busy)
    else $error("busy still high with the final result");

  // More results follow while the final one is not yet shown.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_neighbor |-> busy)
    else $error("busy low in the middle of an emit pass");

  // An error result is a single item at rank 0.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_few |-> (out_data.rank == '0) && out_data.last_neighbor
      && (out_data.neighbor_id == '0))
    else $error("malformed too-few result");

  // Results of one query come on consecutive cycles with ranks counting up.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_neighbor |=>
      out_valid && (out_data.rank == RANK_W'($past(out_data.rank) + RANK_W'(1))))
    else $error("rank sequence broken");

endmodule

bind top_k_similarity_select tksel_checker u_tksel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);

// ===== tb/top_k_similarity_select_test.sv =====
// Self-checking testbench for the top-K similarity selector: directed and random queries.
`timescale 1ns / 1ps

module top_k_similarity_select_test;
  import tksel_pkg::*;

  localparam int KEEP_MAX     = K_MAX_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the selector state and its registers.
  logic [ID_W-1:0]           kept_id [KEEP_MAX];
  logic signed [SCORE_W-1:0] kept_score [KEEP_MAX];
  int unsigned               kept_n;
  logic [NC_W-1:0]           count_reg;
  logic                      clamp_reg;

  out_item_t   expected_neighbors[$];
  out_item_t   want;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          gaps_on = 1'b1;

  top_k_similarity_select #(.K_MAX(KEEP_MAX)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Higher score wins; on equal scores the lower index wins.
  function automatic bit beats(logic signed [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                               logic signed [SCORE_W-1:0] sb, logic [ID_W-1:0] ib);
    return (sa > sb) || ((sa == sb) && (ia < ib));
  endfunction

  function automatic int unsigned eff_count();
    int unsigned k;
    k = count_reg;
    if (k < 1) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    return k;
  endfunction

  function automatic void clear_kept();
    for (int i = 0; i < KEEP_MAX; i++) begin
      kept_id[i] = '0;
      kept_score[i] = '0;
    end
    kept_n = 0;
  endfunction

  // Appends one neighbor to the tail of the expected queue.
  function automatic void queue_neighbor(out_item_t r);
    expected_neighbors = {expected_neighbors, r};
  endfunction

  // Updates the kept list with one accepted item and queues the neighbors it releases.
  task automatic predict_candidate(in_item_t it);
    logic signed [SCORE_W-1:0] s;
    int unsigned k, n, pos;
    out_item_t r;
    k = eff_count();
    if (it.candidate_id != it.query_id) begin
      s = it.candidate_score;
      if (clamp_reg) begin
        if (s > ONE_Q24) s = ONE_Q24;
        if (s < MINUS_ONE_Q24) s = MINUS_ONE_Q24;
      end
      n = (kept_n > k) ? k : kept_n;
      if (n == k && !beats(s, it.candidate_id, kept_score[k-1], kept_id[k-1])) begin
        kept_n = n;
      end else begin
        // A full list drops its worst entry to make room.
        if (n == k) n = k - 1;
        pos = n;
        while (pos > 0 && beats(s, it.candidate_id, kept_score[pos-1], kept_id[pos-1]))
          pos--;
        for (int i = n; i > pos; i--) begin
          kept_id[i] = kept_id[i-1];
          kept_score[i] = kept_score[i-1];
        end
        kept_id[pos] = it.candidate_id;
        kept_score[pos] = s;
        kept_n = n + 1;
      end
    end
    if (!it.last_candidate) return;
    n = (kept_n > k) ? k : kept_n;
    if (n < k) begin
      // Too few neighbors: a single flagged result.
      r = '0;
      r.last_neighbor = 1'b1;
      r.too_few = 1'b1;
      queue_neighbor(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.rank = RANK_W'(i);
        r.neighbor_id = kept_id[i];
        r.neighbor_score = kept_score[i];
        r.last_neighbor = (i + 1 == n);
        r.too_few = 1'b0;
        queue_neighbor(r);
      end
    end
    clear_kept();
  endtask

  // Presents one item, holds it until the block takes it, then idles at random.
  task automatic drive_item(in_item_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_candidate(it);
    if (gaps_on && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Waits until every queued neighbor has come out and the block has settled.
  task automatic drain();
    start <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_NEIGHBOR_COUNT) count_reg = data;
    else clamp_reg = data[0];
    @(posedge clk);
  endtask

  function automatic in_item_t mk_item(logic [ID_W-1:0] qid, logic [ID_W-1:0] cid,
                                       logic signed [SCORE_W-1:0] score, logic last);
    in_item_t it;
    it.query_id = qid;
    it.candidate_id = cid;
    it.candidate_score = score;
    it.last_candidate = last;
    return it;
  endfunction

  // Scores cluster around the clamp limits, small ties and the extremes.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 5))
      0: return SCORE_W'($urandom);
      1: return SCORE_W'(int'(ONE_Q24) + int'($urandom_range(0, 8)) - 4);
      2: return SCORE_W'(int'(MINUS_ONE_Q24) + int'($urandom_range(0, 8)) - 4);
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      4: return SCORE_W'(int'($urandom_range(0, 6)) - 3);
      default: return SCORE_W'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    if ($urandom_range(0, 5) == 0) return ID_W'($urandom);
    return ID_W'($urandom_range(0, 30));
  endfunction

  function automatic logic [NC_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return NC_W'(0);
      1: return NC_W'(1);
      2: return NC_W'(16);
      3: return NC_W'(17);
      4: return NC_W'(31);
      default: return NC_W'($urandom_range(2, 15));
    endcase
  endfunction

  // Fewer candidates than the reset count, with extreme fields and the query itself last.
  task automatic test_too_few();
    drive_item(mk_item(31'd5, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
    drive_item(mk_item(31'd5, 31'd0, 32'sh8000_0000, 1'b0));
    drive_item(mk_item(31'd5, 31'd5, 32'sh0000_0000, 1'b1));
  endtask

  // A count of zero keeps one neighbor; equal scores go to the lower index.
  task automatic test_single_keep_tie();
    drain();
    write_reg(CFG_NEIGHBOR_COUNT, 5'd0);
    drive_item(mk_item(31'd1, 31'd5, 32'sd100, 1'b0));
    drive_item(mk_item(31'd1, 31'd3, 32'sd100, 1'b1));
  endtask

  // Clamping turns the largest score into 1.0, equal to the last item's, so the index decides.
  task automatic test_clamp();
    drain();
    write_reg(CFG_NEIGHBOR_COUNT, 5'd2);
    write_reg(CFG_CLAMP_ENABLE, 5'b11111);
    drive_item(mk_item(31'd0, 31'd9, 32'sh7FFF_FFFF, 1'b0));
    drive_item(mk_item(31'd0, 31'd1, 32'sh8000_0000, 1'b0));
    drive_item(mk_item(31'd0, 31'd4, ONE_Q24, 1'b1));
    drain();
    write_reg(CFG_CLAMP_ENABLE, 5'b11110);
  endtask

  // Lowering the count mid-query drops the tail; then a weak and a strong candidate arrive.
  task automatic test_count_lowered();
    drain();
    write_reg(CFG_NEIGHBOR_COUNT, 5'd4);
    drive_item(mk_item(31'd100, 31'd10, 32'sd40, 1'b0));
    drive_item(mk_item(31'd100, 31'd11, 32'sd30, 1'b0));
    drive_item(mk_item(31'd100, 31'd12, 32'sd20, 1'b0));
    drive_item(mk_item(31'd100, 31'd13, 32'sd10, 1'b0));
    drain();
    write_reg(CFG_NEIGHBOR_COUNT, 5'd2);
    drive_item(mk_item(31'd100, 31'd14, 32'sd5, 1'b0));
    drive_item(mk_item(31'd100, 31'd15, 32'sd35, 1'b1));
  endtask

  // The query's own row still closes the query.
  task automatic test_self_ends_query();
    drain();
    write_reg(CFG_NEIGHBOR_COUNT, 5'd1);
    drive_item(mk_item(31'd2, 31'd7, -32'sd3, 1'b0));
    drive_item(mk_item(31'd2, 31'd2, 32'sd999, 1'b1));
  endtask

  // Mostly full queries with random content, some short ones and occasional count changes.
  task automatic test_random_queries();
    int unsigned sent, queries, k, len;
    logic [ID_W-1:0] qid;
    in_item_t it;
    sent = 0;
    queries = 0;
    while (sent < RANDOM_ITEMS) begin
      if (queries % 5 == 0) begin
        drain();
        write_reg(CFG_NEIGHBOR_COUNT, pick_count());
        write_reg(CFG_CLAMP_ENABLE, CFG_DATA_W'($urandom));
      end
      k = eff_count();
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, k) : $urandom_range(k, k + 8);
      qid = rand_id();
      for (int i = 0; i < len; i++) begin
        gaps_on = !(sent >= 150 && sent < 260);
        it.query_id = qid;
        it.candidate_id = ($urandom_range(0, 7) == 0) ? qid : rand_id();
        it.candidate_score = rand_score();
        it.last_candidate = (i == len - 1);
        drive_item(it);
        sent++;
        if (!it.last_candidate && $urandom_range(0, 39) == 0) begin
          drain();
          write_reg(CFG_NEIGHBOR_COUNT, pick_count());
        end
      end
      queries++;
    end
    gaps_on = 1'b1;
  endtask

  // Compares each result with the oldest queued neighbor.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_neighbors.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %0d", out_data.neighbor_id));
      end else begin
        want = expected_neighbors.pop_front();
        if (out_data.rank !== want.rank)
          report_mismatch($sformatf("rank %0d, want %0d", out_data.rank, want.rank));
        if (out_data.neighbor_id !== want.neighbor_id)
          report_mismatch($sformatf("neighbor_id %0d, want %0d",
                                    out_data.neighbor_id, want.neighbor_id));
        if (out_data.neighbor_score !== want.neighbor_score)
          report_mismatch($sformatf("neighbor_score %h, want %h",
                                    out_data.neighbor_score, want.neighbor_score));
        if (out_data.last_neighbor !== want.last_neighbor)
          report_mismatch($sformatf("last_neighbor %b, want %b",
                                    out_data.last_neighbor, want.last_neighbor));
        if (out_data.too_few !== want.too_few)
          report_mismatch($sformatf("too_few %b, want %b", out_data.too_few, want.too_few));
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clear_kept();
    count_reg = NC_RESET;
    clamp_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_too_few();
    test_single_keep_tie();
    test_clamp();
    test_count_lowered();
    test_self_ends_query();
    test_random_queries();
    drain();
    repeat (6) @(posedge clk);
    if (expected_neighbors.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_neighbors.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tksel_pkg.sv
design/tksel_cell.sv
design/top_k_similarity_select.sv
design/tksel_checker.sv
tb/top_k_similarity_select_test.sv
